// ===== hdl/rv32i_instruction_execute_core_defines.svh =====
// Assertion macros shared by the checker of the execute core.
`ifndef RV32I_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH
`define RV32I_INSTRUCTION_EXECUTE_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RVX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvx check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RVX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvx check failed");

`endif

// ===== hdl/rvx_pkg.sv =====
// Package with the types, codes and constants of the RV32I execute core.
package rvx_pkg;

  localparam int RVX_QUEUE_DEPTH = 2;

  localparam logic [31:0] RVX_START_PC_RST = 32'h0000_0000;
  localparam logic [31:0] RVX_MEM_SIZE_RST = 32'h0001_0000;

  localparam logic CFG_START_PC = 1'b0;
  localparam logic CFG_MEM_SIZE = 1'b1;

  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_LOAD_DATA = 1'b1;

  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_FENCE  = 7'h0f;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
  localparam logic [31:0] INS_EBREAK = 32'h0010_0073;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_ECALL   = 3'd3;
  localparam logic [2:0] ST_EBREAK  = 3'd4;
  localparam logic [2:0] ST_FENCE   = 3'd5;

  localparam logic [2:0] PK_NONE = 3'd0;
  localparam logic [2:0] PK_LB   = 3'd1;
  localparam logic [2:0] PK_LH   = 3'd2;
  localparam logic [2:0] PK_LW   = 3'd3;
  localparam logic [2:0] PK_LBU  = 3'd4;
  localparam logic [2:0] PK_LHU  = 3'd5;

  typedef struct packed {
    logic        op;
    logic [31:0] ins;
    logic [31:0] ld;
    logic [31:0] imm;
    logic        bad;
  } uop_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        mem_valid;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic [2:0]  status;
  } res_t;

endpackage

// ===== hdl/rv32i_instruction_execute_core.sv =====
// Top level of the RV32I execute core: decode queue in front of the execute stage.
//
//   port group | dir | payload
//   in_*       | in  | tuser op; tdata instruction, load_data
//   out_*      | out | tdata next_pc .. status, one result per item
//   cfg_*      | in  | index 0 start_pc, 1 memory_size
//
// One item per cycle is sustained while out_tready holds; an item passes from the
// queue to out_tvalid through operand read, then execute into the result register.
// The register file read is registered, with a bypass from the execute stage.
// rst_n is synchronous; after it the pc holds 0 and memory_size 65536.
// A stalled out_tready fills the result register, the execute stage, then the queue,
// then drops in_tready.
module rv32i_instruction_execute_core
  import rvx_pkg::*;
#(
  parameter int QUEUE_DEPTH = RVX_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // instruction[31:0], load_data[63:32]
  input  logic [0:0]   in_tuser,   // op[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // next_pc, mem_valid, mem_write, mem_address,
                                   // mem_size, store_data, status, zero pad
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic q_valid, q_pop;
  uop_t q_head;
  res_t res;

  assign cfg_ready = 1'b1;

  rvx_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_op   (in_tuser[0]),
    .in_ins  (in_tdata[31:0]),
    .in_ld   (in_tdata[63:32]),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  rvx_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head),
    .cfg_we   (cfg_valid),
    .cfg_sel  (cfg_index[0]),
    .cfg_wdata(cfg_data),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res      (res)
  );

  assign out_tdata = {1'b0, res.status, res.store_data, res.mem_size, res.mem_address,
                      res.mem_write, res.mem_valid, res.next_pc};

endmodule

// ===== hdl/rvx_front.sv =====
// Front end: decodes the immediate and legality of each item and queues it.
module rvx_front
  import rvx_pkg::*;
#(
  parameter int QUEUE_DEPTH = RVX_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_ins,
  input  logic [31:0] in_ld,
  output logic        q_valid,
  input  logic        q_pop,
  output uop_t        q_head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  uop_t          q_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  uop_t          dec;
  logic          push;
  logic [6:0]    opc;
  logic [2:0]    f3;
  logic [6:0]    f7;

  always_comb begin
    opc = in_ins[6:0];
    f3  = in_ins[14:12];
    f7  = in_ins[31:25];
    dec.op  = in_op;
    dec.ins = in_ins;
    dec.ld  = in_ld;
    dec.imm = 32'h0;
    dec.bad = 1'b0;
    unique case (opc)
      OPC_OP: begin
        dec.bad = !((f7 == 7'h00) || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)));
      end
      OPC_OPIMM: begin
        dec.imm = {{20{in_ins[31]}}, in_ins[31:20]};
        if (f3 == 3'd1) begin
          dec.bad = (f7 != 7'h00);
        end else if (f3 == 3'd5) begin
          dec.bad = (f7 != 7'h00) && (f7 != 7'h20);
        end
      end
      OPC_LOAD: begin
        dec.imm = {{20{in_ins[31]}}, in_ins[31:20]};
        dec.bad = (f3 == 3'd3) || (f3 > 3'd5);
      end
      OPC_STORE: begin
        dec.imm = {{20{in_ins[31]}}, in_ins[31:25], in_ins[11:7]};
        dec.bad = (f3 > 3'd2);
      end
      OPC_BRANCH: begin
        dec.imm = {{19{in_ins[31]}}, in_ins[31], in_ins[7], in_ins[30:25],
                   in_ins[11:8], 1'b0};
        dec.bad = (f3 == 3'd2) || (f3 == 3'd3);
      end
      OPC_JALR: begin
        dec.imm = {{20{in_ins[31]}}, in_ins[31:20]};
        dec.bad = (f3 != 3'd0);
      end
      OPC_JAL: begin
        dec.imm = {{11{in_ins[31]}}, in_ins[31], in_ins[19:12], in_ins[20],
                   in_ins[30:21], 1'b0};
      end
      OPC_LUI, OPC_AUIPC: begin
        dec.imm = {in_ins[31:12], 12'h000};
      end
      OPC_FENCE: begin
        dec.bad = (f3 != 3'd0);
      end
      OPC_SYSTEM: begin
        dec.bad = (in_ins != INS_ECALL) && (in_ins != INS_EBREAK);
      end
      default: begin
        dec.bad = 1'b1;
      end
    endcase
    if (in_op == OP_LOAD_DATA) begin
      dec.bad = 1'b0;
    end
  end

  assign in_ready = (cnt_r != CNT_FULL);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_head   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(q_pop);
    end
  end

endmodule

// ===== hdl/rvx_back.sv =====
// Back end: register file, program counter, execute stage and result register.
module rvx_back
  import rvx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  uop_t        q_head,
  input  logic        cfg_we,
  input  logic        cfg_sel,
  input  logic [31:0] cfg_wdata,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res
);

  logic [31:0] rf_mem_r [32];
  logic [31:0] rf_vld_r;
  logic [31:0] a_mem_r, b_mem_r, a_fv_r, b_fv_r;
  logic        a_ok_r, b_ok_r, a_fwd_r, b_fwd_r;
  uop_t        e_r;
  logic        e_valid_r;
  logic [31:0] pc_r, msize_r;
  logic [4:0]  pend_dest_r;
  logic [2:0]  pend_kind_r;
  logic        halted_r;
  res_t        out_r;
  logic        out_valid_r;

  logic        e_fire, e_load;
  logic [31:0] a, b, opd2, alu, npc, pc4, ldv;
  logic [4:0]  rd, rs1, rs2, sh;
  logic [2:0]  f3;
  logic        wr_en, take, halt_set;
  logic [4:0]  wr_addr;
  logic [31:0] wr_data;
  logic [4:0]  pend_dest_nxt;
  logic [2:0]  pend_kind_nxt;
  res_t        r;

  assign e_fire = e_valid_r && (!out_valid_r || res_ready);
  assign e_load = q_valid && (!e_valid_r || e_fire);
  assign q_pop  = e_load;
  assign rs1    = q_head.ins[19:15];
  assign rs2    = q_head.ins[24:20];

  assign a = a_fwd_r ? a_fv_r : (a_ok_r ? a_mem_r : 32'h0);
  assign b = b_fwd_r ? b_fv_r : (b_ok_r ? b_mem_r : 32'h0);

  always_comb begin
    rd   = e_r.ins[11:7];
    f3   = e_r.ins[14:12];
    pc4  = pc_r + 32'd4;
    opd2 = (e_r.ins[6:0] == OPC_OP) ? b : e_r.imm;
    sh   = opd2[4:0];
    unique case (f3)
      3'd0: alu = (e_r.ins[6:0] == OPC_OP && e_r.ins[30]) ? a - b : a + opd2;
      3'd1: alu = a << sh;
      3'd2: alu = {31'h0, $signed(a) < $signed(opd2)};
      3'd3: alu = {31'h0, a < opd2};
      3'd4: alu = a ^ opd2;
      3'd5: alu = e_r.ins[30] ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6: alu = a | opd2;
      default: alu = a & opd2;
    endcase
    unique case (pend_kind_r)
      PK_LB:   ldv = {{24{e_r.ld[7]}}, e_r.ld[7:0]};
      PK_LH:   ldv = {{16{e_r.ld[15]}}, e_r.ld[15:0]};
      PK_LBU:  ldv = {24'h0, e_r.ld[7:0]};
      PK_LHU:  ldv = {16'h0, e_r.ld[15:0]};
      default: ldv = e_r.ld;
    endcase

    r             = '0;
    npc           = pc4;
    wr_en         = 1'b0;
    wr_addr       = rd;
    wr_data       = alu;
    take          = 1'b0;
    halt_set      = 1'b0;
    pend_dest_nxt = pend_dest_r;
    pend_kind_nxt = pend_kind_r;

    if (halted_r) begin
      npc      = pc_r;
      r.status = (pc_r > msize_r) ? ST_RANGE : ST_ILLEGAL;
    end else if (e_r.op == OP_LOAD_DATA) begin
      npc = pc_r;
      if (pend_kind_r != PK_NONE) begin
        wr_en         = 1'b1;
        wr_addr       = pend_dest_r;
        wr_data       = ldv;
        pend_dest_nxt = '0;
        pend_kind_nxt = PK_NONE;
      end
    end else if (e_r.bad) begin
      npc           = pc_r;
      r.status      = ST_ILLEGAL;
      halt_set      = 1'b1;
      pend_dest_nxt = '0;
      pend_kind_nxt = PK_NONE;
    end else begin
      pend_dest_nxt = '0;
      pend_kind_nxt = PK_NONE;
      unique case (e_r.ins[6:0])
        OPC_OP, OPC_OPIMM: wr_en = 1'b1;
        OPC_LOAD: begin
          r.mem_valid   = 1'b1;
          r.mem_address = a + e_r.imm;
          r.mem_size    = f3[1:0];
          pend_dest_nxt = rd;
          unique case (f3)
            3'd0: pend_kind_nxt = PK_LB;
            3'd1: pend_kind_nxt = PK_LH;
            3'd2: pend_kind_nxt = PK_LW;
            3'd4: pend_kind_nxt = PK_LBU;
            default: pend_kind_nxt = PK_LHU;
          endcase
        end
        OPC_STORE: begin
          r.mem_valid   = 1'b1;
          r.mem_write   = 1'b1;
          r.mem_address = a + e_r.imm;
          r.mem_size    = f3[1:0];
          unique case (f3)
            3'd0: r.store_data = {24'h0, b[7:0]};
            3'd1: r.store_data = {16'h0, b[15:0]};
            default: r.store_data = b;
          endcase
        end
        OPC_BRANCH: begin
          unique case (f3)
            3'd0: take = (a == b);
            3'd1: take = (a != b);
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = !($signed(a) < $signed(b));
            3'd6: take = a < b;
            default: take = a >= b;
          endcase
          if (take) begin
            npc = pc_r + e_r.imm;
          end
        end
        OPC_JALR: begin
          npc     = (a + e_r.imm) & 32'hffff_fffe;
          wr_en   = 1'b1;
          wr_data = pc4;
        end
        OPC_JAL: begin
          npc     = pc_r + e_r.imm;
          wr_en   = 1'b1;
          wr_data = pc4;
        end
        OPC_LUI: begin
          wr_en   = 1'b1;
          wr_data = e_r.imm;
        end
        OPC_AUIPC: begin
          wr_en   = 1'b1;
          wr_data = pc_r + e_r.imm;
        end
        OPC_FENCE: r.status = ST_FENCE;
        default: r.status = (e_r.ins == INS_ECALL) ? ST_ECALL : ST_EBREAK;
      endcase
      if (npc > msize_r) begin
        r.status = ST_RANGE;
        halt_set = 1'b1;
      end
    end
    r.next_pc = npc;
    if (wr_addr == 5'd0 || !e_fire) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem_r[wr_addr] <= wr_data;
    end
    if (e_load) begin
      a_mem_r <= rf_mem_r[rs1];
      b_mem_r <= rf_mem_r[rs2];
      a_fv_r  <= wr_data;
      b_fv_r  <= wr_data;
      a_ok_r  <= rf_vld_r[rs1];
      b_ok_r  <= rf_vld_r[rs2];
      a_fwd_r <= wr_en && (wr_addr == rs1);
      b_fwd_r <= wr_en && (wr_addr == rs2);
      e_r     <= q_head;
    end
    if (e_fire) begin
      out_r <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r    <= '0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= RVX_START_PC_RST;
      msize_r     <= RVX_MEM_SIZE_RST;
      pend_dest_r <= '0;
      pend_kind_r <= PK_NONE;
      halted_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        rf_vld_r[wr_addr] <= 1'b1;
      end
      if (e_load) begin
        e_valid_r <= 1'b1;
      end else if (e_fire) begin
        e_valid_r <= 1'b0;
      end
      if (e_fire) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
      if (e_fire) begin
        pend_dest_r <= pend_dest_nxt;
        pend_kind_r <= pend_kind_nxt;
        if (!halted_r && !e_r.bad) begin
          pc_r <= npc;
        end
        if (halt_set) begin
          halted_r <= 1'b1;
        end
      end
      if (cfg_we) begin
        if (cfg_sel == CFG_START_PC) begin
          pc_r        <= cfg_wdata;
          halted_r    <= 1'b0;
          pend_dest_r <= '0;
          pend_kind_r <= PK_NONE;
        end else begin
          msize_r <= cfg_wdata;
        end
      end
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

// ===== hdl/rvx_chk.sv =====
// Port checker of the RV32I execute core, bound to the top level.
`include "rv32i_instruction_execute_core_defines.svh"
module rvx_chk
  import rvx_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  `RVX_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `RVX_ASSERT_IMP(a_ill_nomem, out_tvalid && out_tdata[102:100] == ST_ILLEGAL, !out_tdata[32])
  `RVX_ASSERT_IMP(a_noreq_zero, out_tvalid && !out_tdata[32], out_tdata[99:33] == '0)
  `RVX_ASSERT_IMP(a_load_nodata, out_tvalid && out_tdata[32] && !out_tdata[33],
                  out_tdata[99:68] == '0)

endmodule

bind rv32i_instruction_execute_core rvx_chk u_rvx_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
